// ===== rtl/core/dll_pkg.sv =====
`default_nettype none
package dll_pkg;

	localparam int NODES     = 32;
	localparam int DATA_BITS = 32;
	localparam int IDX_W     = $clog2(NODES);

	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [DATA_BITS-1:0] data_t;

	localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [2:0] REQ_POP_BACK   = 3'd3;
	localparam logic [2:0] REQ_INSERT     = 3'd4;
	localparam logic [2:0] REQ_ERASE      = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_BAD   = 2'd3;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] value_in;
		logic [4:0]         node_handle;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] value_out;
		logic [4:0]         result_handle;
		logic [4:0]         element_count;
	} rsp_t;

	// Store port: one node read address shared by the link and value memories,
	// one free-stack read address, one write port per memory.
	typedef struct packed {
		idx_t  node_raddr;
		idx_t  fs_raddr;
		logic  nx_we;
		idx_t  nx_waddr;
		idx_t  nx_wdata;
		logic  pv_we;
		idx_t  pv_waddr;
		idx_t  pv_wdata;
		logic  val_we;
		idx_t  val_waddr;
		data_t val_wdata;
		logic  fs_we;
		idx_t  fs_waddr;
		idx_t  fs_wdata;
	} mem_cmd_t;

	typedef struct packed {
		idx_t  nx;
		idx_t  pv;
		data_t val;
		idx_t  fs;
	} mem_rd_t;

endpackage
`default_nettype wire

// ===== rtl/core/dll_store.sv =====
`default_nettype none
module dll_store (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dll_pkg::mem_cmd_t cmd,
	output dll_pkg::mem_rd_t       rd
);
	import dll_pkg::*;

	idx_t  nx_mem  [NODES];
	idx_t  pv_mem  [NODES];
	data_t val_mem [NODES];
	idx_t  fs_mem  [NODES];

	logic [NODES-1:0] fs_vld_q;

	idx_t  nx_rd_q;
	idx_t  pv_rd_q;
	data_t val_rd_q;
	idx_t  fs_rd_q;
	idx_t  fs_addr_q;
	logic  fs_hit_q;

	always_ff @(posedge clk) begin
		if (cmd.nx_we) begin
			nx_mem[cmd.nx_waddr] <= cmd.nx_wdata;
		end
		if (cmd.pv_we) begin
			pv_mem[cmd.pv_waddr] <= cmd.pv_wdata;
		end
		if (cmd.val_we) begin
			val_mem[cmd.val_waddr] <= cmd.val_wdata;
		end
		if (cmd.fs_we) begin
			fs_mem[cmd.fs_waddr] <= cmd.fs_wdata;
		end
		nx_rd_q   <= nx_mem[cmd.node_raddr];
		pv_rd_q   <= pv_mem[cmd.node_raddr];
		val_rd_q  <= val_mem[cmd.node_raddr];
		fs_rd_q   <= fs_mem[cmd.fs_raddr];
		fs_addr_q <= cmd.fs_raddr;
		fs_hit_q  <= fs_vld_q[cmd.fs_raddr];
	end

	// free-stack entries never written since reset hold their index plus one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_vld_q <= '0;
		end else if (cmd.fs_we) begin
			fs_vld_q[cmd.fs_waddr] <= 1'b1;
		end
	end

	assign rd.nx  = nx_rd_q;
	assign rd.pv  = pv_rd_q;
	assign rd.val = val_rd_q;
	assign rd.fs  = fs_hit_q ? fs_rd_q : fs_addr_q + 1'b1;

endmodule
`default_nettype wire

// ===== rtl/core/dll_seq.sv =====
`default_nettype none
module dll_seq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire dll_pkg::req_t     req,
	input  wire logic              out_space,
	output logic                   rsp_valid,
	output dll_pkg::rsp_t          rsp,
	output dll_pkg::mem_cmd_t      cmd,
	input  wire dll_pkg::mem_rd_t  rd
);
	import dll_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_LINK2} state_t;

	state_t           state_q;
	idx_t             head_q;
	idx_t             tail_q;
	idx_t             fc_q;
	logic [NODES-1:0] in_use_q;

	logic [1:0] status_s1;
	logic       do_ins_s1;
	logic       do_rem_s1;
	idx_t       node_s1;
	data_t      val_s1;
	idx_t       n_s2;

	idx_t       h_idx;
	logic       h_ok;
	logic       full;
	logic       empty;
	logic [1:0] st;
	logic       do_ins;
	logic       do_rem;
	idx_t       tgt;
	idx_t       pv_eff;
	idx_t       nx_eff;
	idx_t       fc_nxt;
	logic       exec_go;
	logic       link_go;

	assign req_ready = (state_q == S_IDLE);

	// request decode, against the state as it stands at accept
	always_comb begin
		h_idx  = IDX_W'(req.node_handle);
		h_ok   = (32'(req.node_handle) < 32'(NODES)) &&
		         ((req.node_handle == '0) || in_use_q[h_idx]);
		full   = (fc_q == '0);
		empty  = (fc_q == IDX_W'(NODES - 1));
		st     = ST_OK;
		do_ins = 1'b0;
		do_rem = 1'b0;
		tgt    = '0;
		unique case (req.req_type)
			REQ_PUSH_FRONT: begin
				tgt = head_q;
				if (full) st = ST_FULL;
				else do_ins = 1'b1;
			end
			REQ_PUSH_BACK: begin
				if (full) st = ST_FULL;
				else do_ins = 1'b1;
			end
			REQ_POP_FRONT: begin
				tgt = head_q;
				if (empty) st = ST_EMPTY;
				else do_rem = 1'b1;
			end
			REQ_POP_BACK: begin
				tgt = tail_q;
				if (empty) st = ST_EMPTY;
				else do_rem = 1'b1;
			end
			REQ_INSERT: begin
				tgt = h_idx;
				if (!h_ok) st = ST_BAD;
				else if (full) st = ST_FULL;
				else do_ins = 1'b1;
			end
			REQ_ERASE: begin
				tgt = h_idx;
				if (empty) st = ST_EMPTY;
				else if (!h_ok || req.node_handle == '0) st = ST_BAD;
				else do_rem = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// sentinel links live in head_q/tail_q; data read from memory entry 0 is never used
	assign pv_eff  = (node_s1 == '0) ? tail_q : rd.pv;
	assign nx_eff  = (node_s1 == '0) ? head_q : rd.nx;
	assign exec_go = (state_q == S_EXEC) && (do_ins_s1 || out_space);
	assign link_go = (state_q == S_LINK2) && out_space;

	always_comb begin
		cmd            = '0;
		cmd.node_raddr = (state_q == S_IDLE) ? tgt : node_s1;
		cmd.fs_raddr   = fc_q - 1'b1;
		if (exec_go && do_ins_s1) begin
			cmd.nx_we     = 1'b1;
			cmd.nx_waddr  = pv_eff;
			cmd.nx_wdata  = rd.fs;
			cmd.pv_we     = 1'b1;
			cmd.pv_waddr  = rd.fs;
			cmd.pv_wdata  = pv_eff;
			cmd.val_we    = 1'b1;
			cmd.val_waddr = rd.fs;
			cmd.val_wdata = val_s1;
		end else if (exec_go && do_rem_s1) begin
			cmd.nx_we    = 1'b1;
			cmd.nx_waddr = pv_eff;
			cmd.nx_wdata = nx_eff;
			cmd.pv_we    = 1'b1;
			cmd.pv_waddr = nx_eff;
			cmd.pv_wdata = pv_eff;
			cmd.fs_we    = 1'b1;
			cmd.fs_waddr = fc_q;
			cmd.fs_wdata = node_s1;
		end else if (link_go) begin
			cmd.nx_we    = 1'b1;
			cmd.nx_waddr = n_s2;
			cmd.nx_wdata = node_s1;
			cmd.pv_we    = 1'b1;
			cmd.pv_waddr = node_s1;
			cmd.pv_wdata = n_s2;
		end
	end

	always_comb begin
		rsp_valid = (exec_go && !do_ins_s1) || link_go;
		fc_nxt    = fc_q;
		rsp       = '0;
		if (state_q == S_LINK2) begin
			rsp.status        = ST_OK;
			rsp.result_handle = 5'(n_s2);
		end else begin
			rsp.status = status_s1;
			if (do_rem_s1) begin
				fc_nxt            = fc_q + 1'b1;
				rsp.value_out     = 32'($signed(rd.val));
				rsp.result_handle = 5'(node_s1);
			end
		end
		rsp.element_count = 5'(IDX_W'(NODES - 1) - fc_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			fc_q     <= IDX_W'(NODES - 1);
			in_use_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (exec_go) begin
						if (do_ins_s1) begin
							state_q         <= S_LINK2;
							fc_q            <= fc_q - 1'b1;
							in_use_q[rd.fs] <= 1'b1;
							if (pv_eff == '0) head_q <= rd.fs;
						end else begin
							state_q <= S_IDLE;
							if (do_rem_s1) begin
								fc_q              <= fc_q + 1'b1;
								in_use_q[node_s1] <= 1'b0;
								if (pv_eff == '0) head_q <= nx_eff;
								if (nx_eff == '0) tail_q <= pv_eff;
							end
						end
					end
				end
				S_LINK2: begin
					if (link_go) begin
						state_q <= S_IDLE;
						if (node_s1 == '0) tail_q <= n_s2;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			status_s1 <= st;
			do_ins_s1 <= do_ins;
			do_rem_s1 <= do_rem;
			node_s1   <= tgt;
			val_s1    <= DATA_BITS'($unsigned(req.value_in));
		end
		if (state_q == S_EXEC && do_ins_s1) begin
			n_s2 <= rd.fs;
		end
	end

	a_head_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == '0) == (fc_q == IDX_W'(NODES - 1)))
		else $error("head link disagrees with free count");

	a_tail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_LINK2) |-> ((tail_q == '0) == (head_q == '0)))
		else $error("head and tail links disagree on empty list");

	a_in_use_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(in_use_q) == (NODES - 1 - int'(fc_q)))
		else $error("in-use flags disagree with free count");

	a_sentinel_free: assert property (@(posedge clk) disable iff (!arst_n)
		!in_use_q[0])
		else $error("sentinel marked as allocated");

endmodule
`default_nettype wire

// ===== rtl/core/doubly_linked_list_engine.sv =====
`default_nettype none
// Circular doubly linked list with a sentinel (node 0) over a pool of
// dll_pkg::NODES nodes; free nodes sit on a stack and an erased or popped node
// goes back on top of it. Links, values and the free stack live in synchronous
// memories with one read and one write port each, the sentinel links in
// registers. A pop, an erase, a failed request or an unknown request type goes
// through S_EXEC; a successful push or insert also goes through S_LINK2,
// because it rewrites two entries of each link memory and each has one write
// port. One request is worked on at a time; the result register lets the next
// request be accepted while a result still waits on out_ready. No clearing pass after reset.
module doubly_linked_list_engine (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire dll_pkg::req_t  in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output dll_pkg::rsp_t       out_data
);
	import dll_pkg::*;

	mem_cmd_t cmd;
	mem_rd_t  rd;
	logic     rsp_valid;
	rsp_t     rsp;
	logic     out_space;
	logic     out_valid_q;
	rsp_t     out_data_q;

	assign out_space = !out_valid_q || out_ready;

	dll_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_valid),
		.req_ready (in_ready),
		.req       (in_data),
		.out_space (out_space),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cmd       (cmd),
		.rd        (rd)
	);

	dll_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rd     (rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_valid) begin
			out_data_q <= rsp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire
